@@ hw/rtl/ahps_pkg.sv @@
package ahps_pkg;

  // Number of path entries in use; the action index wraps past the last one.
  localparam int unsigned PathLen = 8;

  // Standard pressure 101325 Pa in 1/256 Pa and the 100 m height limit.
  localparam logic [24:0] StdPressure = 25'd25939200;
  localparam logic [24:0] HeightLimit = 25'd307328;

  // round(d * 256000 / 12005) is (d * HeightRecip + HeightBias) >> 32, exact
  // for every d up to the height limit.
  localparam logic [36:0] HeightRecip = 37'd91587807395;
  localparam logic [55:0] HeightBias  = 56'd2147304766;
  localparam logic signed [23:0] HeightOffset = 24'sd3476;

  localparam logic signed [24:0] Q16One     = 25'sd65536;
  localparam logic signed [24:0] ErrThresh  = 25'sd3277;
  localparam logic signed [24:0] MoveThresh = 25'sd262;

  // floor(x / 19) is (x * ClimbRecip) >> 22 for any x below 2^18.
  localparam logic [17:0] ClimbRecip = 18'd220753;
  localparam logic [17:0] ClimbRound = 18'd9;

  localparam logic signed [23:0] WeightClimb   = 24'sd976191;
  localparam logic signed [23:0] WeightBrake   = 24'sd946700;
  localparam logic signed [23:0] WeightHover   = 24'sd976191;
  localparam logic signed [23:0] WeightHigh    = 24'sd974553;
  localparam logic signed [23:0] WeightAct     = 24'sd975536;
  localparam logic signed [23:0] WeightHighAct = 24'sd973898;

  localparam logic signed [23:0] PitchBase     = -24'sd3260;
  localparam logic signed [23:0] PitchFwd      = 24'sd16;
  localparam logic signed [23:0] PitchFwdBrake = -24'sd9814;
  localparam logic signed [23:0] YawHalfPi     = 24'sd102944;

  // Phase boundaries of one path entry.
  localparam logic [6:0] TickGoEnd    = 7'd39;
  localparam logic [6:0] TickBrakeEnd = 7'd50;
  localparam logic [6:0] TickTurnEnd  = 7'd60;
  localparam logic [6:0] TickAdvance  = 7'd80;

  localparam logic [15:0] PathCodesReset = 16'h9999;

  // Path entry action codes.
  localparam logic [1:0] CodeFwd  = 2'd1;
  localparam logic [1:0] CodeTurn = 2'd2;

  typedef struct packed {
    logic [6:0] phase_tick;
    logic [2:0] action_index;
  } ahps_seq_t;

  typedef struct packed {
    logic signed [23:0] thrust;
    logic signed [23:0] pitch;
    logic signed [23:0] yaw;
  } ahps_cmd_t;

endpackage

@@ hw/rtl/ahps_height.sv @@
module ahps_height
  import ahps_pkg::*;
(
  input  logic [24:0]        pressure_i,
  output logic               in_range_o,
  output logic signed [23:0] height_o
);

  logic [24:0] p_diff;
  logic [55:0] prod;
  logic [55:0] scaled;

  always_comb begin
    if (pressure_i >= StdPressure) begin
      p_diff = pressure_i - StdPressure;
    end else begin
      p_diff = StdPressure - pressure_i;
    end
    prod   = 56'(p_diff[18:0]) * 56'(HeightRecip);
    scaled = prod + HeightBias;
  end

  assign in_range_o = (p_diff <= HeightLimit);
  assign height_o   = $signed(scaled[55:32]) - HeightOffset;

endmodule

@@ hw/rtl/ahps_cmd.sv @@
module ahps_cmd
  import ahps_pkg::*;
(
  input  logic signed [23:0] height_i,
  input  logic signed [23:0] prev_height_i,
  input  logic [15:0]        path_codes_i,
  input  ahps_seq_t          seq_i,
  output ahps_cmd_t          cmd_o,
  output ahps_seq_t          seq_o
);

  logic signed [24:0] err;
  logic signed [24:0] delta;
  logic signed [24:0] delta_abs;
  logic               climb;
  logic               moving;
  logic               high;
  logic [17:0]        climb_num;
  logic [35:0]        climb_prod;
  logic [1:0]         code;
  logic               fwd;
  logic               turn;
  logic signed [23:0] w_act;
  logic [2:0]         idx_inc;

  always_comb begin
    err        = Q16One - 25'(height_i);
    delta      = 25'(height_i) - 25'(prev_height_i);
    delta_abs  = delta[24] ? -delta : delta;
    climb      = (err >= ErrThresh);
    moving     = (delta_abs > MoveThresh);
    high       = (err <= -ErrThresh);
    // Error is below 2^17 whenever the climb term is used.
    climb_num  = {err[16:0], 1'b0} + ClimbRound;
    climb_prod = 36'(climb_num) * 36'(ClimbRecip);
    code       = path_codes_i[{seq_i.action_index, 1'b0} +: 2];
    fwd        = (code == CodeFwd);
    turn       = (code == CodeTurn);
    w_act      = high ? WeightHighAct : WeightAct;
    idx_inc    = seq_i.action_index + 3'd1;

    cmd_o.pitch = PitchBase;
    cmd_o.yaw   = '0;
    seq_o       = seq_i;

    if (climb) begin
      cmd_o.thrust = WeightClimb + $signed({10'd0, climb_prod[35:22]});
    end else if (moving) begin
      cmd_o.thrust = WeightBrake;
    end else begin
      cmd_o.thrust = high ? WeightHigh : WeightHover;
      seq_o.phase_tick = seq_i.phase_tick + 7'd1;
      if (seq_i.phase_tick <= TickGoEnd) begin
        if (fwd) begin
          cmd_o.pitch = PitchFwd;
        end
        if (turn) begin
          cmd_o.yaw = -YawHalfPi;
        end
        cmd_o.thrust = w_act;
      end else if (seq_i.phase_tick <= TickBrakeEnd) begin
        if (fwd) begin
          cmd_o.pitch = PitchFwdBrake;
        end
        if (turn) begin
          cmd_o.yaw = YawHalfPi;
        end
        cmd_o.thrust = w_act;
      end else if (seq_i.phase_tick <= TickTurnEnd) begin
        if (turn) begin
          cmd_o.pitch = PitchFwd;
        end
        cmd_o.thrust = w_act;
      end else if (seq_i.phase_tick == TickAdvance) begin
        // The tick restarts at zero and then counts this sample.
        seq_o.phase_tick = 7'd1;
        if (idx_inc > 3'(PathLen - 1)) begin
          seq_o.action_index = '0;
        end else begin
          seq_o.action_index = idx_inc;
        end
      end
    end
  end

endmodule

@@ hw/rtl/altitude_hold_path_sequencer_top.sv @@
// Channel  | Direction | Handshake              | Payload
// ---------+-----------+------------------------+----------------------------------
// in       | input     | in_valid_i/in_ready_o  | pressure_i (25b, 1/256 Pa)
// out      | output    | out_valid_o/out_ready_i| thrust_o, pitch_o, yaw_o (Q8.16)
// cfg      | input     | cfg_we_i (no wait)     | cfg_wdata_i (path codes, 16b)
//
// One beat per cycle in each direction while the output is not stalled; a result
// passes through the height register, then the command register with the state.
// Samples beyond the height limit either way are dropped at the height register.
// Reset clears the state and the valid flags and loads the default path codes.
// A stalled output holds both stages; the input is taken again as soon as the
// height stage can move on.
module altitude_hold_path_sequencer_top
  import ahps_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [24:0]        pressure_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [23:0] thrust_o,
  output logic signed [23:0] pitch_o,
  output logic signed [23:0] yaw_o,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_wdata_i
);

  logic [15:0]        path_codes_q;
  logic               hgt_valid_q, hgt_valid_d;
  logic signed [23:0] height_q;
  logic signed [23:0] prev_height_q;
  ahps_seq_t          seq_q, seq_d;
  logic               out_valid_q, out_valid_d;
  ahps_cmd_t          cmd_q, cmd_d;

  logic               in_range;
  logic signed [23:0] height;
  logic               stall;
  logic               in_fire;
  logic               cmd_load;

  ahps_height u_height (
    .pressure_i (pressure_i),
    .in_range_o (in_range),
    .height_o   (height)
  );

  ahps_cmd u_cmd (
    .height_i      (height_q),
    .prev_height_i (prev_height_q),
    .path_codes_i  (path_codes_q),
    .seq_i         (seq_q),
    .cmd_o         (cmd_d),
    .seq_o         (seq_d)
  );

  assign stall      = out_valid_q && !out_ready_i;
  assign cmd_load   = hgt_valid_q && !stall;
  assign in_ready_o = !hgt_valid_q || !stall;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    hgt_valid_d = hgt_valid_q;
    if (in_fire) begin
      hgt_valid_d = in_range;
    end else if (cmd_load) begin
      hgt_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (cmd_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      path_codes_q  <= PathCodesReset;
      hgt_valid_q   <= 1'b0;
      out_valid_q   <= 1'b0;
      prev_height_q <= '0;
      seq_q         <= '0;
    end else begin
      if (cfg_we_i) begin
        path_codes_q <= cfg_wdata_i;
      end
      hgt_valid_q <= hgt_valid_d;
      out_valid_q <= out_valid_d;
      if (cmd_load) begin
        prev_height_q <= height_q;
        seq_q         <= seq_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      height_q <= height;
    end
    if (cmd_load) begin
      cmd_q <= cmd_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign thrust_o    = cmd_q.thrust;
  assign pitch_o     = cmd_q.pitch;
  assign yaw_o       = cmd_q.yaw;

  // The phase tick never runs past the advance point.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_q.phase_tick <= TickAdvance)
    else $error("phase tick beyond advance point");

  // The action index stays inside the path.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(seq_q.action_index) < PathLen)
    else $error("action index outside path");

  // A height waiting behind a stalled output is kept.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    hgt_valid_q && stall |=> hgt_valid_q && $stable(height_q))
    else $error("height stage lost a beat during stall");

  // An in-range sample always reaches the height stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_range |=> hgt_valid_q)
    else $error("in-range sample dropped");

endmodule
